// ===== design/lss_pkg.sv =====
package lss_pkg;

  typedef enum logic [3:0] {
    MD_IMP  = 4'd0,
    MD_IMM  = 4'd1,
    MD_ZP   = 4'd2,
    MD_ZPX  = 4'd3,
    MD_ZPY  = 4'd4,
    MD_ABS  = 4'd5,
    MD_ABX  = 4'd6,
    MD_ABY  = 4'd7,
    MD_INX  = 4'd8,
    MD_INY  = 4'd9,
    MD_PUSH = 4'd10,
    MD_PULL = 4'd11,
    MD_BAD  = 4'd12
  } mode_e;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_X = 2'd1,
    REG_Y = 2'd2,
    REG_P = 2'd3
  } reg_e;

  typedef struct packed {
    mode_e mode;
    reg_e  rsel;
    logic  store;
  } dec_t;

  localparam logic [2:0] STEP_FETCH = 3'd0;
  localparam logic [2:0] STEP_OPND  = 3'd1;
  localparam logic [2:0] STEP_HIGH  = 3'd2;
  localparam logic [2:0] STEP_PTRHI = 3'd3;
  localparam logic [2:0] STEP_DATA  = 3'd4;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] SP_RESET   = 8'hFF;
  localparam logic [15:0] START_RESET = 16'hFFFC;

  localparam logic [7:0] OP_NOP = 8'hEA;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABY = 8'hB9;
  localparam logic [7:0] OP_LDA_INX = 8'hA1;
  localparam logic [7:0] OP_LDA_INY = 8'hB1;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS = 8'hAE;
  localparam logic [7:0] OP_LDX_ABY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS = 8'hAC;
  localparam logic [7:0] OP_LDY_ABX = 8'hBC;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STA_ZPX = 8'h95;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STA_ABX = 8'h9D;
  localparam logic [7:0] OP_STA_ABY = 8'h99;
  localparam logic [7:0] OP_STA_INX = 8'h81;
  localparam logic [7:0] OP_STA_INY = 8'h91;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STX_ZPY = 8'h96;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STY_ZPX = 8'h94;
  localparam logic [7:0] OP_STY_ABS = 8'h8C;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_PLP = 8'h28;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic [7:0]  op;
    logic [2:0]  step;
    logic [15:0] ea;
    logic [7:0]  ptr;
  } state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        done;
    logic        bad;
  } req_t;

endpackage

// ===== design/lss_decode.sv =====
module lss_decode (
  input  logic [7:0]   op_i,
  output lss_pkg::dec_t dec_o
);

  always_comb begin
    dec_o.mode  = lss_pkg::MD_BAD;
    dec_o.rsel  = lss_pkg::REG_A;
    dec_o.store = 1'b0;
    unique case (op_i)
      lss_pkg::OP_NOP, lss_pkg::OP_TAX, lss_pkg::OP_TAY, lss_pkg::OP_TXA,
      lss_pkg::OP_TYA, lss_pkg::OP_TSX, lss_pkg::OP_TXS: dec_o.mode = lss_pkg::MD_IMP;
      lss_pkg::OP_LDA_IMM: dec_o.mode = lss_pkg::MD_IMM;
      lss_pkg::OP_LDA_ZP:  dec_o.mode = lss_pkg::MD_ZP;
      lss_pkg::OP_LDA_ZPX: dec_o.mode = lss_pkg::MD_ZPX;
      lss_pkg::OP_LDA_ABS: dec_o.mode = lss_pkg::MD_ABS;
      lss_pkg::OP_LDA_ABX: dec_o.mode = lss_pkg::MD_ABX;
      lss_pkg::OP_LDA_ABY: dec_o.mode = lss_pkg::MD_ABY;
      lss_pkg::OP_LDA_INX: dec_o.mode = lss_pkg::MD_INX;
      lss_pkg::OP_LDA_INY: dec_o.mode = lss_pkg::MD_INY;
      lss_pkg::OP_LDX_IMM: begin dec_o.mode = lss_pkg::MD_IMM; dec_o.rsel = lss_pkg::REG_X; end
      lss_pkg::OP_LDX_ZP:  begin dec_o.mode = lss_pkg::MD_ZP;  dec_o.rsel = lss_pkg::REG_X; end
      lss_pkg::OP_LDX_ZPY: begin dec_o.mode = lss_pkg::MD_ZPY; dec_o.rsel = lss_pkg::REG_X; end
      lss_pkg::OP_LDX_ABS: begin dec_o.mode = lss_pkg::MD_ABS; dec_o.rsel = lss_pkg::REG_X; end
      lss_pkg::OP_LDX_ABY: begin dec_o.mode = lss_pkg::MD_ABY; dec_o.rsel = lss_pkg::REG_X; end
      lss_pkg::OP_LDY_IMM: begin dec_o.mode = lss_pkg::MD_IMM; dec_o.rsel = lss_pkg::REG_Y; end
      lss_pkg::OP_LDY_ZP:  begin dec_o.mode = lss_pkg::MD_ZP;  dec_o.rsel = lss_pkg::REG_Y; end
      lss_pkg::OP_LDY_ZPX: begin dec_o.mode = lss_pkg::MD_ZPX; dec_o.rsel = lss_pkg::REG_Y; end
      lss_pkg::OP_LDY_ABS: begin dec_o.mode = lss_pkg::MD_ABS; dec_o.rsel = lss_pkg::REG_Y; end
      lss_pkg::OP_LDY_ABX: begin dec_o.mode = lss_pkg::MD_ABX; dec_o.rsel = lss_pkg::REG_Y; end
      lss_pkg::OP_STA_ZP:  begin dec_o.mode = lss_pkg::MD_ZP;  dec_o.store = 1'b1; end
      lss_pkg::OP_STA_ZPX: begin dec_o.mode = lss_pkg::MD_ZPX; dec_o.store = 1'b1; end
      lss_pkg::OP_STA_ABS: begin dec_o.mode = lss_pkg::MD_ABS; dec_o.store = 1'b1; end
      lss_pkg::OP_STA_ABX: begin dec_o.mode = lss_pkg::MD_ABX; dec_o.store = 1'b1; end
      lss_pkg::OP_STA_ABY: begin dec_o.mode = lss_pkg::MD_ABY; dec_o.store = 1'b1; end
      lss_pkg::OP_STA_INX: begin dec_o.mode = lss_pkg::MD_INX; dec_o.store = 1'b1; end
      lss_pkg::OP_STA_INY: begin dec_o.mode = lss_pkg::MD_INY; dec_o.store = 1'b1; end
      lss_pkg::OP_STX_ZP: begin
        dec_o.mode = lss_pkg::MD_ZP; dec_o.rsel = lss_pkg::REG_X; dec_o.store = 1'b1;
      end
      lss_pkg::OP_STX_ZPY: begin
        dec_o.mode = lss_pkg::MD_ZPY; dec_o.rsel = lss_pkg::REG_X; dec_o.store = 1'b1;
      end
      lss_pkg::OP_STX_ABS: begin
        dec_o.mode = lss_pkg::MD_ABS; dec_o.rsel = lss_pkg::REG_X; dec_o.store = 1'b1;
      end
      lss_pkg::OP_STY_ZP: begin
        dec_o.mode = lss_pkg::MD_ZP; dec_o.rsel = lss_pkg::REG_Y; dec_o.store = 1'b1;
      end
      lss_pkg::OP_STY_ZPX: begin
        dec_o.mode = lss_pkg::MD_ZPX; dec_o.rsel = lss_pkg::REG_Y; dec_o.store = 1'b1;
      end
      lss_pkg::OP_STY_ABS: begin
        dec_o.mode = lss_pkg::MD_ABS; dec_o.rsel = lss_pkg::REG_Y; dec_o.store = 1'b1;
      end
      lss_pkg::OP_PHA: dec_o.mode = lss_pkg::MD_PUSH;
      lss_pkg::OP_PHP: begin dec_o.mode = lss_pkg::MD_PUSH; dec_o.rsel = lss_pkg::REG_P; end
      lss_pkg::OP_PLA: dec_o.mode = lss_pkg::MD_PULL;
      lss_pkg::OP_PLP: begin dec_o.mode = lss_pkg::MD_PULL; dec_o.rsel = lss_pkg::REG_P; end
      default: dec_o.mode = lss_pkg::MD_BAD;
    endcase
  end

endmodule

// ===== design/lss_step.sv =====
module lss_step (
  input  logic            cmd_i,
  input  logic [7:0]      data_i,
  input  logic [15:0]     start_i,
  input  lss_pkg::state_t st_i,
  output lss_pkg::state_t st_o,
  output lss_pkg::req_t   req_o
);

  lss_pkg::dec_t cur_dec;
  lss_pkg::dec_t new_dec;
  logic          ld_en;
  lss_pkg::reg_e ld_reg;
  logic [7:0]    ld_val;
  logic [15:0]   abs_sum;
  logic [15:0]   ind_sum;
  logic [7:0]    acc_sel;

  lss_decode u_dec_cur (.op_i(st_i.op), .dec_o(cur_dec));
  lss_decode u_dec_new (.op_i(data_i),  .dec_o(new_dec));

  function automatic logic [7:0] reg_read(lss_pkg::state_t s, lss_pkg::reg_e r);
    logic [7:0] v;
    unique case (r)
      lss_pkg::REG_X: v = s.x;
      lss_pkg::REG_Y: v = s.y;
      lss_pkg::REG_P: v = s.p;
      default:        v = s.acc;
    endcase
    return v;
  endfunction

  always_comb begin
    abs_sum = {data_i, st_i.ptr};
    if (cur_dec.mode == lss_pkg::MD_ABX) begin
      abs_sum = abs_sum + {8'h00, st_i.x};
    end else if (cur_dec.mode == lss_pkg::MD_ABY) begin
      abs_sum = abs_sum + {8'h00, st_i.y};
    end
    ind_sum = {data_i, st_i.ea[7:0]};
    if (cur_dec.mode == lss_pkg::MD_INY) begin
      ind_sum = ind_sum + {8'h00, st_i.y};
    end
    acc_sel = reg_read(st_i, cur_dec.rsel);
  end

  always_comb begin
    st_o   = st_i;
    req_o  = '0;
    req_o.addr = st_i.pc;
    ld_en  = 1'b0;
    ld_reg = lss_pkg::REG_A;
    ld_val = data_i;
    if (!cmd_i) begin
      st_o      = '0;
      st_o.sp   = lss_pkg::SP_RESET;
      st_o.pc   = start_i;
      req_o.addr = start_i;
    end else begin
      unique case (st_i.step)
        lss_pkg::STEP_FETCH: begin
          st_o.op = data_i;
          st_o.pc = st_i.pc + 16'd1;
          unique case (new_dec.mode)
            lss_pkg::MD_IMP: begin
              req_o.done = 1'b1;
              unique case (data_i)
                lss_pkg::OP_TAX: begin ld_en = 1'b1; ld_reg = lss_pkg::REG_X; ld_val = st_i.acc; end
                lss_pkg::OP_TAY: begin ld_en = 1'b1; ld_reg = lss_pkg::REG_Y; ld_val = st_i.acc; end
                lss_pkg::OP_TXA: begin ld_en = 1'b1; ld_reg = lss_pkg::REG_A; ld_val = st_i.x; end
                lss_pkg::OP_TYA: begin ld_en = 1'b1; ld_reg = lss_pkg::REG_A; ld_val = st_i.y; end
                lss_pkg::OP_TSX: begin ld_en = 1'b1; ld_reg = lss_pkg::REG_X; ld_val = st_i.sp; end
                lss_pkg::OP_TXS: st_o.sp = st_i.x;
                default: ;
              endcase
            end
            lss_pkg::MD_BAD: begin
              req_o.done = 1'b1;
              req_o.bad  = 1'b1;
            end
            lss_pkg::MD_PUSH: begin
              req_o.addr  = {lss_pkg::STACK_PAGE, st_i.sp};
              req_o.wr    = 1'b1;
              req_o.wdata = reg_read(st_i, new_dec.rsel);
              st_o.sp     = st_i.sp - 8'd1;
              st_o.step   = lss_pkg::STEP_DATA;
            end
            lss_pkg::MD_PULL: begin
              st_o.sp    = st_i.sp + 8'd1;
              req_o.addr = {lss_pkg::STACK_PAGE, st_i.sp + 8'd1};
              st_o.step  = lss_pkg::STEP_DATA;
            end
            default: begin
              req_o.addr = st_i.pc + 16'd1;
              st_o.step  = lss_pkg::STEP_OPND;
            end
          endcase
        end
        lss_pkg::STEP_OPND: begin
          st_o.pc = st_i.pc + 16'd1;
          unique case (cur_dec.mode)
            lss_pkg::MD_IMM: begin
              ld_en = 1'b1; ld_reg = cur_dec.rsel; req_o.done = 1'b1;
            end
            lss_pkg::MD_ZP, lss_pkg::MD_ZPX, lss_pkg::MD_ZPY: begin
              if (cur_dec.mode == lss_pkg::MD_ZPX) begin
                st_o.ea = {8'h00, data_i + st_i.x};
              end else if (cur_dec.mode == lss_pkg::MD_ZPY) begin
                st_o.ea = {8'h00, data_i + st_i.y};
              end else begin
                st_o.ea = {8'h00, data_i};
              end
              req_o.addr  = st_o.ea;
              req_o.wr    = cur_dec.store;
              req_o.wdata = cur_dec.store ? acc_sel : 8'h00;
              st_o.step   = lss_pkg::STEP_DATA;
            end
            lss_pkg::MD_ABS, lss_pkg::MD_ABX, lss_pkg::MD_ABY: begin
              st_o.ptr   = data_i;
              req_o.addr = st_i.pc + 16'd1;
              st_o.step  = lss_pkg::STEP_HIGH;
            end
            lss_pkg::MD_INX: begin
              st_o.ptr   = data_i + st_i.x;
              req_o.addr = {8'h00, data_i + st_i.x};
              st_o.step  = lss_pkg::STEP_HIGH;
            end
            lss_pkg::MD_INY: begin
              st_o.ptr   = data_i;
              req_o.addr = {8'h00, data_i};
              st_o.step  = lss_pkg::STEP_HIGH;
            end
            default: req_o.done = 1'b1;
          endcase
        end
        lss_pkg::STEP_HIGH: begin
          if (cur_dec.mode == lss_pkg::MD_ABS || cur_dec.mode == lss_pkg::MD_ABX ||
              cur_dec.mode == lss_pkg::MD_ABY) begin
            st_o.pc     = st_i.pc + 16'd1;
            st_o.ea     = abs_sum;
            req_o.addr  = abs_sum;
            req_o.wr    = cur_dec.store;
            req_o.wdata = cur_dec.store ? acc_sel : 8'h00;
            st_o.step   = lss_pkg::STEP_DATA;
          end else if (cur_dec.mode == lss_pkg::MD_INX || cur_dec.mode == lss_pkg::MD_INY) begin
            st_o.ea    = {8'h00, data_i};
            req_o.addr = {8'h00, st_i.ptr + 8'd1};
            st_o.step  = lss_pkg::STEP_PTRHI;
          end else begin
            req_o.done = 1'b1;
          end
        end
        lss_pkg::STEP_PTRHI: begin
          if (cur_dec.mode == lss_pkg::MD_INX || cur_dec.mode == lss_pkg::MD_INY) begin
            st_o.ea     = ind_sum;
            req_o.addr  = ind_sum;
            req_o.wr    = cur_dec.store;
            req_o.wdata = cur_dec.store ? acc_sel : 8'h00;
            st_o.step   = lss_pkg::STEP_DATA;
          end else begin
            req_o.done = 1'b1;
          end
        end
        lss_pkg::STEP_DATA: begin
          req_o.done = 1'b1;
          if (cur_dec.mode == lss_pkg::MD_PULL) begin
            if (cur_dec.rsel == lss_pkg::REG_P) begin
              st_o.p = data_i;
            end else begin
              ld_en = 1'b1; ld_reg = cur_dec.rsel;
            end
          end else if (cur_dec.mode != lss_pkg::MD_PUSH && cur_dec.mode != lss_pkg::MD_IMP &&
                       cur_dec.mode != lss_pkg::MD_BAD && !cur_dec.store) begin
            ld_en = 1'b1; ld_reg = cur_dec.rsel;
          end
        end
        default: req_o.done = 1'b1;
      endcase
      if (ld_en) begin
        unique case (ld_reg)
          lss_pkg::REG_X: st_o.x = ld_val;
          lss_pkg::REG_Y: st_o.y = ld_val;
          default:        st_o.acc = ld_val;
        endcase
        st_o.p = {ld_val[7], st_o.p[6:2], (ld_val == 8'h00), st_o.p[0]};
      end
      if (req_o.done) begin
        st_o.step   = lss_pkg::STEP_FETCH;
        req_o.addr  = st_o.pc;
        req_o.wr    = 1'b0;
        req_o.wdata = 8'h00;
      end
    end
  end

endmodule

// ===== design/cpu_load_store_stack_core.sv =====
// Bus-cycle core for loads, stores, register transfers and stack push/pull of an
// 8-bit processor. Each input item reports one finished bus cycle (tuser = 0
// resets the core) with the byte read; each item yields exactly one result item
// with the next bus request and a register snapshot. Items pass an input register
// and combinational step logic into a result register: one item per clock is
// sustained while m_axis_tready is high; a stalled output holds the item in the
// input register. start_address is written by cfg_we/cfg_wdata.
module cpu_load_store_stack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // read_data
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_address, bus_write, write_data, instruction_done, invalid_opcode,
  // acc_value, x_value, y_value, stack_value, flags_value, pc_value, zero pad
  output logic [87:0] m_axis_tdata
);

  logic            in_vld_q;
  logic            cmd_q;
  logic [7:0]      data_q;
  logic            out_vld_q;
  logic [87:0]     out_q;
  logic [15:0]     start_q;
  logic            advance;
  lss_pkg::state_t st_q;
  lss_pkg::state_t st_d;
  lss_pkg::req_t   req;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  lss_step u_step (
    .cmd_i  (cmd_q),
    .data_i (data_q),
    .start_i(start_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .req_o  (req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= lss_pkg::START_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{sp: lss_pkg::SP_RESET, pc: lss_pkg::START_RESET, default: '0};
    end else begin
      if (cfg_we) begin
        start_q <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q  <= s_axis_tuser;
      data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= {5'd0, st_d.pc, st_d.p, st_d.sp, st_d.y, st_d.x, st_d.acc,
                req.bad, req.done, req.wdata, req.wr, req.addr};
    end
  end

  a_bad_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[26] || m_axis_tdata[25]))
    else $error("invalid opcode flagged without completion");

  a_wdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16] || m_axis_tdata[24:17] == 8'h00))
    else $error("write data nonzero on a read");

  a_done_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req.done) |=> (st_q.step == lss_pkg::STEP_FETCH))
    else $error("sequencer not back at fetch after completion");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both stages are stalled");

endmodule

// ===== sim/cpu_load_store_stack_core_checker.sv =====
`timescale 1ns / 100ps

module cpu_load_store_stack_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic [7:0]  y;
    logic [7:0]  x;
    logic [7:0]  acc;
    logic        bad;
    logic        done;
    logic [7:0]  wdata;
    logic        wr;
    logic [15:0] addr;
  } bus_cycle_t;

  logic [15:0] start_q;
  logic [7:0]  acc_q, x_q, y_q, sp_q, p_q, op_q, ptr_q;
  logic [15:0] pc_q, ea_q;
  logic [2:0]  step_q;
  bus_cycle_t  expected_q[$];

  function automatic lss_pkg::dec_t decode_op(logic [7:0] op);
    lss_pkg::dec_t d;
    d = '{mode: lss_pkg::MD_BAD, rsel: lss_pkg::REG_A, store: 1'b0};
    case (op)
      lss_pkg::OP_NOP, lss_pkg::OP_TAX, lss_pkg::OP_TAY, lss_pkg::OP_TXA,
      lss_pkg::OP_TYA, lss_pkg::OP_TSX, lss_pkg::OP_TXS: d.mode = lss_pkg::MD_IMP;
      lss_pkg::OP_LDA_IMM: d.mode = lss_pkg::MD_IMM;
      lss_pkg::OP_LDA_ZP:  d.mode = lss_pkg::MD_ZP;
      lss_pkg::OP_LDA_ZPX: d.mode = lss_pkg::MD_ZPX;
      lss_pkg::OP_LDA_ABS: d.mode = lss_pkg::MD_ABS;
      lss_pkg::OP_LDA_ABX: d.mode = lss_pkg::MD_ABX;
      lss_pkg::OP_LDA_ABY: d.mode = lss_pkg::MD_ABY;
      lss_pkg::OP_LDA_INX: d.mode = lss_pkg::MD_INX;
      lss_pkg::OP_LDA_INY: d.mode = lss_pkg::MD_INY;
      lss_pkg::OP_LDX_IMM: d = '{lss_pkg::MD_IMM, lss_pkg::REG_X, 1'b0};
      lss_pkg::OP_LDX_ZP:  d = '{lss_pkg::MD_ZP, lss_pkg::REG_X, 1'b0};
      lss_pkg::OP_LDX_ZPY: d = '{lss_pkg::MD_ZPY, lss_pkg::REG_X, 1'b0};
      lss_pkg::OP_LDX_ABS: d = '{lss_pkg::MD_ABS, lss_pkg::REG_X, 1'b0};
      lss_pkg::OP_LDX_ABY: d = '{lss_pkg::MD_ABY, lss_pkg::REG_X, 1'b0};
      lss_pkg::OP_LDY_IMM: d = '{lss_pkg::MD_IMM, lss_pkg::REG_Y, 1'b0};
      lss_pkg::OP_LDY_ZP:  d = '{lss_pkg::MD_ZP, lss_pkg::REG_Y, 1'b0};
      lss_pkg::OP_LDY_ZPX: d = '{lss_pkg::MD_ZPX, lss_pkg::REG_Y, 1'b0};
      lss_pkg::OP_LDY_ABS: d = '{lss_pkg::MD_ABS, lss_pkg::REG_Y, 1'b0};
      lss_pkg::OP_LDY_ABX: d = '{lss_pkg::MD_ABX, lss_pkg::REG_Y, 1'b0};
      lss_pkg::OP_STA_ZP:  d = '{lss_pkg::MD_ZP, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_ZPX: d = '{lss_pkg::MD_ZPX, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_ABS: d = '{lss_pkg::MD_ABS, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_ABX: d = '{lss_pkg::MD_ABX, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_ABY: d = '{lss_pkg::MD_ABY, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_INX: d = '{lss_pkg::MD_INX, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STA_INY: d = '{lss_pkg::MD_INY, lss_pkg::REG_A, 1'b1};
      lss_pkg::OP_STX_ZP:  d = '{lss_pkg::MD_ZP, lss_pkg::REG_X, 1'b1};
      lss_pkg::OP_STX_ZPY: d = '{lss_pkg::MD_ZPY, lss_pkg::REG_X, 1'b1};
      lss_pkg::OP_STX_ABS: d = '{lss_pkg::MD_ABS, lss_pkg::REG_X, 1'b1};
      lss_pkg::OP_STY_ZP:  d = '{lss_pkg::MD_ZP, lss_pkg::REG_Y, 1'b1};
      lss_pkg::OP_STY_ZPX: d = '{lss_pkg::MD_ZPX, lss_pkg::REG_Y, 1'b1};
      lss_pkg::OP_STY_ABS: d = '{lss_pkg::MD_ABS, lss_pkg::REG_Y, 1'b1};
      lss_pkg::OP_PHA: d = '{lss_pkg::MD_PUSH, lss_pkg::REG_A, 1'b0};
      lss_pkg::OP_PHP: d = '{lss_pkg::MD_PUSH, lss_pkg::REG_P, 1'b0};
      lss_pkg::OP_PLA: d = '{lss_pkg::MD_PULL, lss_pkg::REG_A, 1'b0};
      lss_pkg::OP_PLP: d = '{lss_pkg::MD_PULL, lss_pkg::REG_P, 1'b0};
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    return (p & 8'h7D) | {v[7], 5'd0, (v == 8'd0), 1'b0};
  endfunction

  function automatic logic [7:0] reg_of(lss_pkg::reg_e r);
    case (r)
      lss_pkg::REG_X: return x_q;
      lss_pkg::REG_Y: return y_q;
      lss_pkg::REG_P: return p_q;
      default: return acc_q;
    endcase
  endfunction

  task automatic load_reg(lss_pkg::reg_e r, logic [7:0] v);
    case (r)
      lss_pkg::REG_X: x_q = v;
      lss_pkg::REG_Y: y_q = v;
      default: acc_q = v;
    endcase
    p_q = with_nz(p_q, v);
  endtask

  task automatic clear_core();
    acc_q = '0; x_q = '0; y_q = '0; sp_q = lss_pkg::SP_RESET; p_q = '0;
    pc_q = start_q; op_q = '0; step_q = lss_pkg::STEP_FETCH; ea_q = '0; ptr_q = '0;
  endtask

  task automatic start_data_access(lss_pkg::reg_e r, logic st, inout bus_cycle_t c);
    c.addr = ea_q;
    if (st) begin
      c.wr = 1'b1;
      c.wdata = reg_of(r);
    end
    step_q = lss_pkg::STEP_DATA;
  endtask

  task automatic predict_bus_cycle(logic cmd, logic [7:0] d);
    bus_cycle_t c;
    lss_pkg::dec_t dc;
    logic [15:0] a;
    c = '0;
    c.addr = pc_q;
    if (!cmd) begin
      clear_core();
      c.addr = pc_q;
    end else begin
      dc = decode_op(op_q);
      case (step_q)
        lss_pkg::STEP_FETCH: begin
          op_q = d;
          pc_q = pc_q + 16'd1;
          dc = decode_op(d);
          case (dc.mode)
            lss_pkg::MD_IMP: begin
              case (d)
                lss_pkg::OP_TAX: begin x_q = acc_q; p_q = with_nz(p_q, x_q); end
                lss_pkg::OP_TAY: begin y_q = acc_q; p_q = with_nz(p_q, y_q); end
                lss_pkg::OP_TXA: begin acc_q = x_q; p_q = with_nz(p_q, acc_q); end
                lss_pkg::OP_TYA: begin acc_q = y_q; p_q = with_nz(p_q, acc_q); end
                lss_pkg::OP_TSX: begin x_q = sp_q; p_q = with_nz(p_q, x_q); end
                lss_pkg::OP_TXS: sp_q = x_q;
                default: ;
              endcase
              c.done = 1'b1;
            end
            lss_pkg::MD_BAD: begin
              c.done = 1'b1;
              c.bad = 1'b1;
            end
            lss_pkg::MD_PUSH: begin
              c.addr = {lss_pkg::STACK_PAGE, sp_q};
              c.wr = 1'b1;
              c.wdata = reg_of(dc.rsel);
              sp_q = sp_q - 8'd1;
              step_q = lss_pkg::STEP_DATA;
            end
            lss_pkg::MD_PULL: begin
              sp_q = sp_q + 8'd1;
              c.addr = {lss_pkg::STACK_PAGE, sp_q};
              step_q = lss_pkg::STEP_DATA;
            end
            default: begin
              c.addr = pc_q;
              step_q = lss_pkg::STEP_OPND;
            end
          endcase
        end
        lss_pkg::STEP_OPND: begin
          pc_q = pc_q + 16'd1;
          case (dc.mode)
            lss_pkg::MD_IMM: begin load_reg(dc.rsel, d); c.done = 1'b1; end
            lss_pkg::MD_ZP: begin
              ea_q = {8'd0, d};
              start_data_access(dc.rsel, dc.store, c);
            end
            lss_pkg::MD_ZPX: begin
              ea_q = {8'd0, d + x_q};
              start_data_access(dc.rsel, dc.store, c);
            end
            lss_pkg::MD_ZPY: begin
              ea_q = {8'd0, d + y_q};
              start_data_access(dc.rsel, dc.store, c);
            end
            lss_pkg::MD_ABS, lss_pkg::MD_ABX, lss_pkg::MD_ABY: begin
              ptr_q = d; c.addr = pc_q; step_q = lss_pkg::STEP_HIGH;
            end
            lss_pkg::MD_INX: begin
              ptr_q = d + x_q; c.addr = {8'd0, ptr_q}; step_q = lss_pkg::STEP_HIGH;
            end
            lss_pkg::MD_INY: begin
              ptr_q = d; c.addr = {8'd0, ptr_q}; step_q = lss_pkg::STEP_HIGH;
            end
            default: c.done = 1'b1;
          endcase
        end
        lss_pkg::STEP_HIGH: begin
          if (dc.mode inside {lss_pkg::MD_ABS, lss_pkg::MD_ABX, lss_pkg::MD_ABY}) begin
            pc_q = pc_q + 16'd1;
            a = {d, ptr_q};
            if (dc.mode == lss_pkg::MD_ABX) a = a + {8'd0, x_q};
            if (dc.mode == lss_pkg::MD_ABY) a = a + {8'd0, y_q};
            ea_q = a;
            start_data_access(dc.rsel, dc.store, c);
          end else if (dc.mode inside {lss_pkg::MD_INX, lss_pkg::MD_INY}) begin
            ea_q = {8'd0, d};
            c.addr = {8'd0, ptr_q + 8'd1};
            step_q = lss_pkg::STEP_PTRHI;
          end else c.done = 1'b1;
        end
        lss_pkg::STEP_PTRHI: begin
          if (dc.mode inside {lss_pkg::MD_INX, lss_pkg::MD_INY}) begin
            a = {d, ea_q[7:0]};
            if (dc.mode == lss_pkg::MD_INY) a = a + {8'd0, y_q};
            ea_q = a;
            start_data_access(dc.rsel, dc.store, c);
          end else c.done = 1'b1;
        end
        lss_pkg::STEP_DATA: begin
          if (dc.mode == lss_pkg::MD_PULL) begin
            if (dc.rsel == lss_pkg::REG_P) p_q = d;
            else load_reg(dc.rsel, d);
          end else if (!(dc.mode inside {lss_pkg::MD_PUSH, lss_pkg::MD_IMP, lss_pkg::MD_BAD})
                       && !dc.store) begin
            load_reg(dc.rsel, d);
          end
          c.done = 1'b1;
        end
        default: c.done = 1'b1;
      endcase
      if (c.done) begin
        step_q = lss_pkg::STEP_FETCH;
        c.addr = pc_q;
        c.wr = 1'b0;
        c.wdata = '0;
      end
    end
    if (!c.wr) c.wdata = '0;
    c.acc = acc_q; c.x = x_q; c.y = y_q; c.sp = sp_q; c.p = p_q; c.pc = pc_q;
    expected_q.push_back(c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bus_cycle_t got, want;
    if (!rst_ni) begin
      start_q = lss_pkg::START_RESET;
      clear_core();
      expected_q.delete();
      fail_count_o <= 0;
      results_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[82:0];
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_bus_cycle(s_axis_tuser, s_axis_tdata);
      if (cfg_we) start_q = cfg_wdata;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== sim/cpu_load_store_stack_core_tb.sv =====
`timescale 1ns / 100ps

module cpu_load_store_stack_core_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  int          fail_count, pending, results;
  int          idle_pct = 0;
  bit          hold_off = 1'b0;
  int          sent = 0;
  int          quiet_cycles = 0;

  cpu_load_store_stack_core uut (
    .clk_i, .rst_ni, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  cpu_load_store_stack_core_checker checker_i (
    .clk_i, .rst_ni, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold the item until taken; drop valid only while idling
  task automatic send_item(logic cmd, logic [7:0] d);
    bit idle;
    idle = ($urandom_range(99) < idle_pct);
    if (idle) begin
      s_axis_tvalid <= 1'b0;
      while (idle) begin
        @(posedge clk_i);
        idle = ($urandom_range(99) < idle_pct);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // one opcode with operand bytes; bus cycle reads go back as random data
  task automatic run_op(logic [7:0] op, int extra);
    send_item(1'b1, op);
    repeat (extra) send_item(1'b1, 8'($urandom));
  endtask

  function automatic int extra_bytes(logic [7:0] op);
    case (op)
      lss_pkg::OP_NOP, lss_pkg::OP_TAX, lss_pkg::OP_TAY, lss_pkg::OP_TXA,
      lss_pkg::OP_TYA, lss_pkg::OP_TSX, lss_pkg::OP_TXS: return 0;
      lss_pkg::OP_LDA_IMM, lss_pkg::OP_LDX_IMM, lss_pkg::OP_LDY_IMM, lss_pkg::OP_PHA,
      lss_pkg::OP_PHP, lss_pkg::OP_PLA, lss_pkg::OP_PLP: return 1;
      lss_pkg::OP_LDA_ZP, lss_pkg::OP_LDX_ZP, lss_pkg::OP_LDY_ZP, lss_pkg::OP_STA_ZP,
      lss_pkg::OP_STX_ZP, lss_pkg::OP_STY_ZP, lss_pkg::OP_LDA_ZPX, lss_pkg::OP_LDY_ZPX,
      lss_pkg::OP_LDX_ZPY, lss_pkg::OP_STA_ZPX, lss_pkg::OP_STX_ZPY,
      lss_pkg::OP_STY_ZPX: return 2;
      lss_pkg::OP_LDA_INX, lss_pkg::OP_LDA_INY, lss_pkg::OP_STA_INX,
      lss_pkg::OP_STA_INY: return 4;
      lss_pkg::OP_LDA_ABS, lss_pkg::OP_LDA_ABX, lss_pkg::OP_LDA_ABY, lss_pkg::OP_LDX_ABS,
      lss_pkg::OP_LDX_ABY, lss_pkg::OP_LDY_ABS, lss_pkg::OP_LDY_ABX, lss_pkg::OP_STA_ABS,
      lss_pkg::OP_STA_ABX, lss_pkg::OP_STA_ABY, lss_pkg::OP_STX_ABS,
      lss_pkg::OP_STY_ABS: return 3;
      default: return 0;
    endcase
  endfunction

  logic [7:0] ops[] = '{lss_pkg::OP_NOP, lss_pkg::OP_TAX, lss_pkg::OP_TAY,
    lss_pkg::OP_TXA, lss_pkg::OP_TYA, lss_pkg::OP_TSX, lss_pkg::OP_TXS,
    lss_pkg::OP_LDA_IMM, lss_pkg::OP_LDA_ZP, lss_pkg::OP_LDA_ZPX, lss_pkg::OP_LDA_ABS,
    lss_pkg::OP_LDA_ABX, lss_pkg::OP_LDA_ABY, lss_pkg::OP_LDA_INX, lss_pkg::OP_LDA_INY,
    lss_pkg::OP_LDX_IMM, lss_pkg::OP_LDX_ZP, lss_pkg::OP_LDX_ZPY, lss_pkg::OP_LDX_ABS,
    lss_pkg::OP_LDX_ABY, lss_pkg::OP_LDY_IMM, lss_pkg::OP_LDY_ZP, lss_pkg::OP_LDY_ZPX,
    lss_pkg::OP_LDY_ABS, lss_pkg::OP_LDY_ABX, lss_pkg::OP_STA_ZP, lss_pkg::OP_STA_ZPX,
    lss_pkg::OP_STA_ABS, lss_pkg::OP_STA_ABX, lss_pkg::OP_STA_ABY, lss_pkg::OP_STA_INX,
    lss_pkg::OP_STA_INY, lss_pkg::OP_STX_ZP, lss_pkg::OP_STX_ZPY, lss_pkg::OP_STX_ABS,
    lss_pkg::OP_STY_ZP, lss_pkg::OP_STY_ZPX, lss_pkg::OP_STY_ABS, lss_pkg::OP_PHA,
    lss_pkg::OP_PHP, lss_pkg::OP_PLA, lss_pkg::OP_PLP};

  logic [15:0] starts[] = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFC};

  initial begin
    logic [7:0] op;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bus cycle before any reset command, then extremes and special cases
    send_item(1'b1, lss_pkg::OP_LDA_IMM);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hFF);
    run_op(lss_pkg::OP_LDA_IMM, 0); send_item(1'b1, 8'h80);
    run_op(lss_pkg::OP_LDX_IMM, 0); send_item(1'b1, 8'hFF);
    run_op(lss_pkg::OP_LDA_ABX, 0); send_item(1'b1, 8'hFF); send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h55);
    run_op(lss_pkg::OP_TXS, 0);
    run_op(lss_pkg::OP_PHA, 1);
    run_op(lss_pkg::OP_PLA, 1);
    run_op(lss_pkg::OP_PLP, 1);
    run_op(8'h02, 0);
    run_op(lss_pkg::OP_LDA_INX, 0); send_item(1'b1, 8'hFF); send_item(1'b1, 8'h34);
    send_item(1'b1, 8'h12); send_item(1'b1, 8'h00);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (30) run_op(lss_pkg::OP_NOP, 0);
    join
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      write_start(phase == 3 ? 16'($urandom) : starts[phase]);
      send_item(1'b0, 8'($urandom));
      idle_pct = (phase == 1) ? 0 : 32;
      while (sent < 200 + 300 * (phase + 1)) begin
        if ($urandom_range(99) < 6) begin
          send_item($urandom_range(9) != 0, 8'($urandom));
        end else begin
          op = ops[$urandom_range(ops.size() - 1)];
          run_op(op, extra_bytes(op));
        end
      end
      wait_drained();
    end

    write_start(lss_pkg::START_RESET);
    send_item(1'b0, 8'h00);
    run_op(lss_pkg::OP_TSX, 0);
    wait_drained();

    $display("Covered %0d bus cycles, %0d results: all opcodes, undefined ones,", sent, results);
    $display("resets, four start addresses, stalls and a long output hold-off.");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
